@@ hdl/gdzc_pkg.sv @@
// ----------------------------------------------------------------------------
// gdzc_pkg
// Types, register map and pipeline layout for the dead-zone conditioner.
// ----------------------------------------------------------------------------
package gdzc_pkg;

   typedef struct packed {
      logic [7:0]         left_trigger_raw;
      logic [7:0]         right_trigger_raw;
      logic signed [15:0] left_x_raw;
      logic signed [15:0] left_y_raw;
      logic signed [15:0] right_x_raw;
      logic signed [15:0] right_y_raw;
   } req_type;

   typedef struct packed {
      logic [14:0]        left_trigger_out;
      logic [14:0]        right_trigger_out;
      logic signed [15:0] left_x_out;
      logic signed [15:0] left_y_out;
      logic signed [15:0] right_x_out;
      logic signed [15:0] right_y_out;
   } rsp_type;

   // Register map, word index on paddr[3:2].
   localparam int          CSR_ADDR_W            = 4;
   localparam logic [1:0]  CSR_TRIGGER_THRESHOLD = 2'd0;
   localparam logic [1:0]  CSR_LEFT_DEAD_ZONE    = 2'd1;
   localparam logic [1:0]  CSR_RIGHT_DEAD_ZONE   = 2'd2;

   localparam logic [7:0]  TRIGGER_THRESHOLD_RST = 8'd30;
   localparam logic [14:0] LEFT_DEAD_ZONE_RST    = 15'd7849;
   localparam logic [14:0] RIGHT_DEAD_ZONE_RST   = 15'd8689;

   // Arithmetic widths.
   localparam int ROOT_W      = 16;
   localparam int RAD_W       = 32;
   localparam int SQRT_REM_W  = ROOT_W + 2;
   localparam int QUO_W       = 16;
   localparam int STICK_DIV_W = 31;
   localparam int TRIG_DIV_W  = 8;

   // Iteration split over stages.
   localparam int SQRT_STEPS  = 4;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = QUO_W / DIV_STEPS;

   // Stick pipeline layout (stage numbers start at 1).
   localparam int STG_ABS    = 1;
   localparam int STG_SQUARE = 2;
   localparam int STG_SUM    = 3;
   localparam int STG_SQRT0  = 4;
   localparam int STG_RADIUS = STG_SQRT0 + SQRT_STAGES;
   localparam int STG_MUL    = STG_RADIUS + 1;
   localparam int STG_DIV0   = STG_MUL + 1;
   localparam int STG_OUT    = STG_DIV0 + DIV_STAGES;
   localparam int PIPE_DEPTH = STG_OUT;

   // Trigger pipeline layout; the result is then delayed to PIPE_DEPTH.
   localparam int TRG_PREP = 1;
   localparam int TRG_DIV0 = TRG_PREP + 1;
   localparam int TRG_SAT  = TRG_DIV0 + DIV_STAGES;

   typedef struct packed {
      logic [15:0] ax;
      logic [15:0] ay;
      logic        sx;
      logic        sy;
   } stick_side_type;

   typedef struct packed {
      logic zero;
      logic sx;
      logic sy;
   } div_side_type;

endpackage

@@ hdl/gdzc_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// gdzc_sqrt_stage
// Registered slice of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module gdzc_sqrt_stage #(
   parameter int STEPS = gdzc_pkg::SQRT_STEPS
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [gdzc_pkg::RAD_W-1:0]        rad_in,
   input  logic [gdzc_pkg::ROOT_W-1:0]       root_in,
   input  logic [gdzc_pkg::SQRT_REM_W-1:0]   rem_in,
   output logic [gdzc_pkg::RAD_W-1:0]        rad_out,
   output logic [gdzc_pkg::ROOT_W-1:0]       root_out,
   output logic [gdzc_pkg::SQRT_REM_W-1:0]   rem_out
);

   localparam int RW = gdzc_pkg::SQRT_REM_W;
   localparam int QW = gdzc_pkg::ROOT_W;
   localparam int AW = gdzc_pkg::RAD_W;

   logic [AW-1:0] rad_c,  rad_ff;
   logic [QW-1:0] root_c, root_ff;
   logic [RW-1:0] rem_c,  rem_ff;
   logic [RW+1:0] sh_c;
   logic [RW+1:0] trial_c;

   always_comb begin
      rad_c   = rad_in;
      root_c  = root_in;
      rem_c   = rem_in;
      sh_c    = '0;
      trial_c = '0;
      for (int k = 0; k < STEPS; k++) begin
         sh_c    = {rem_c, rad_c[AW-1:AW-2]};
         trial_c = {2'b00, root_c, 2'b01};
         if (sh_c >= trial_c) begin
            rem_c  = RW'(sh_c - trial_c);
            root_c = {root_c[QW-2:0], 1'b1};
         end else begin
            rem_c  = sh_c[RW-1:0];
            root_c = {root_c[QW-2:0], 1'b0};
         end
         rad_c = {rad_c[AW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_c;
         root_ff <= root_c;
         rem_ff  <= rem_c;
      end
   end

   assign rad_out  = rad_ff;
   assign root_out = root_ff;
   assign rem_out  = rem_ff;

endmodule

@@ hdl/gdzc_div_stage.sv @@
// ----------------------------------------------------------------------------
// gdzc_div_stage
// Registered slice of a restoring divider with a 16-bit quotient.
// ----------------------------------------------------------------------------
module gdzc_div_stage #(
   parameter int W     = gdzc_pkg::STICK_DIV_W,
   parameter int STEPS = gdzc_pkg::DIV_STEPS
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [W-1:0]                rem_in,
   input  logic [W-1:0]                den_in,
   input  logic [gdzc_pkg::QUO_W-1:0]  low_in,
   input  logic [gdzc_pkg::QUO_W-1:0]  quo_in,
   output logic [W-1:0]                rem_out,
   output logic [W-1:0]                den_out,
   output logic [gdzc_pkg::QUO_W-1:0]  low_out,
   output logic [gdzc_pkg::QUO_W-1:0]  quo_out
);

   localparam int QW = gdzc_pkg::QUO_W;

   logic [W-1:0]  rem_c, rem_ff, den_ff;
   logic [QW-1:0] low_c, low_ff, quo_c, quo_ff;
   logic [W:0]    sh_c;

   // Bits of the dividend still to come are shifted in from low.
   always_comb begin
      rem_c = rem_in;
      low_c = low_in;
      quo_c = quo_in;
      sh_c  = '0;
      for (int k = 0; k < STEPS; k++) begin
         sh_c = {rem_c, low_c[QW-1]};
         if (sh_c >= {1'b0, den_in}) begin
            rem_c = W'(sh_c - {1'b0, den_in});
            quo_c = {quo_c[QW-2:0], 1'b1};
         end else begin
            rem_c = sh_c[W-1:0];
            quo_c = {quo_c[QW-2:0], 1'b0};
         end
         low_c = {low_c[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_c;
         den_ff <= den_in;
         low_ff <= low_c;
         quo_ff <= quo_c;
      end
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign low_out = low_ff;
   assign quo_out = quo_ff;

endmodule

@@ hdl/gdzc_trigger.sv @@
// ----------------------------------------------------------------------------
// gdzc_trigger
// Trigger path: threshold, rescale by a pipelined divide, saturate, delay.
// ----------------------------------------------------------------------------
module gdzc_trigger (
   input  logic                            clock,
   input  logic [gdzc_pkg::PIPE_DEPTH:1]   en,
   input  logic [7:0]                      raw,
   input  logic [7:0]                      thr,
   output logic [14:0]                     trig_out
);

   localparam int DW = gdzc_pkg::TRIG_DIV_W;
   localparam int QW = gdzc_pkg::QUO_W;
   localparam int NS = gdzc_pkg::DIV_STAGES;

   logic [DW-1:0] rem_w [NS+1];
   logic [DW-1:0] den_w [NS+1];
   logic [QW-1:0] low_w [NS+1];
   logic [QW-1:0] quo_w [NS+1];
   logic          zero_ff [gdzc_pkg::TRG_PREP:gdzc_pkg::TRG_SAT-1];
   logic [14:0]   dly_ff  [gdzc_pkg::TRG_SAT:gdzc_pkg::PIPE_DEPTH];
   logic [DW-1:0] diff_c;
   logic [DW-1:0] rem0_ff, den0_ff;
   logic [QW-1:0] low0_ff;

   assign diff_c = raw - thr;

   // Dividend is diff * 2^15; its top part seeds the remainder.
   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::TRG_PREP]) begin
         zero_ff[gdzc_pkg::TRG_PREP] <= (raw <= thr);
         rem0_ff <= {1'b0, diff_c[DW-1:1]};
         low0_ff <= {diff_c[0], {(QW-1){1'b0}}};
         den0_ff <= ~thr;
      end
   end

   assign rem_w[0] = rem0_ff;
   assign den_w[0] = den0_ff;
   assign low_w[0] = low0_ff;
   assign quo_w[0] = '0;

   for (genvar g = 0; g < NS; g++) begin : g_div
      gdzc_div_stage #(.W(DW), .STEPS(gdzc_pkg::DIV_STEPS)) u_div (
         .clock   (clock),
         .en      (en[gdzc_pkg::TRG_DIV0 + g]),
         .rem_in  (rem_w[g]),
         .den_in  (den_w[g]),
         .low_in  (low_w[g]),
         .quo_in  (quo_w[g]),
         .rem_out (rem_w[g+1]),
         .den_out (den_w[g+1]),
         .low_out (low_w[g+1]),
         .quo_out (quo_w[g+1])
      );
      always_ff @(posedge clock) begin
         if (en[gdzc_pkg::TRG_DIV0 + g]) begin
            zero_ff[gdzc_pkg::TRG_DIV0 + g] <= zero_ff[gdzc_pkg::TRG_PREP + g];
         end
      end
   end

   // A full-travel result of 32768 saturates to 32767.
   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::TRG_SAT]) begin
         if (zero_ff[gdzc_pkg::TRG_SAT-1]) begin
            dly_ff[gdzc_pkg::TRG_SAT] <= '0;
         end else if (quo_w[NS][QW-1]) begin
            dly_ff[gdzc_pkg::TRG_SAT] <= 15'h7FFF;
         end else begin
            dly_ff[gdzc_pkg::TRG_SAT] <= quo_w[NS][14:0];
         end
      end
   end

   for (genvar s = gdzc_pkg::TRG_SAT + 1; s <= gdzc_pkg::PIPE_DEPTH; s++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en[s]) begin
            dly_ff[s] <= dly_ff[s-1];
         end
      end
   end

   assign trig_out = dly_ff[gdzc_pkg::PIPE_DEPTH];

endmodule

@@ hdl/gdzc_stick.sv @@
// ----------------------------------------------------------------------------
// gdzc_stick
// Stick path: radius by pipelined square root, radial rescale by two
// pipelined dividers, sign restore and saturation.
// ----------------------------------------------------------------------------
module gdzc_stick (
   input  logic                            clock,
   input  logic [gdzc_pkg::PIPE_DEPTH:1]   en,
   input  logic signed [15:0]              x_in,
   input  logic signed [15:0]              y_in,
   input  logic [14:0]                     dz,
   output logic signed [15:0]              x_out,
   output logic signed [15:0]              y_out
);

   localparam int SQ = gdzc_pkg::SQRT_STAGES;
   localparam int NS = gdzc_pkg::DIV_STAGES;
   localparam int DW = gdzc_pkg::STICK_DIV_W;
   localparam int QW = gdzc_pkg::QUO_W;

   gdzc_pkg::stick_side_type side1_ff, side2_ff, side3_ff, side_rad_ff;
   gdzc_pkg::stick_side_type side_sq [SQ+1];
   gdzc_pkg::div_side_type   side_mul_ff;
   gdzc_pkg::div_side_type   side_div [NS+1];

   logic [31:0]                      sqx2_ff, sqy2_ff;
   logic [gdzc_pkg::RAD_W-1:0]       rad_w  [SQ+1];
   logic [gdzc_pkg::ROOT_W-1:0]      root_w [SQ+1];
   logic [gdzc_pkg::SQRT_REM_W-1:0]  srem_w [SQ+1];
   logic [gdzc_pkg::RAD_W-1:0]       sum3_ff;

   logic [15:0] r_c, rc_c;
   logic        zero_rad_ff;
   logic [15:0] r_rad_ff, nd_rad_ff, dd_rad_ff;

   logic [DW-1:0] nx_ff, ny_ff, den_ff;

   logic [DW-1:0] xrem_w [NS+1];
   logic [DW-1:0] xden_w [NS+1];
   logic [QW-1:0] xlow_w [NS+1];
   logic [QW-1:0] xquo_w [NS+1];
   logic [DW-1:0] yrem_w [NS+1];
   logic [DW-1:0] yden_w [NS+1];
   logic [QW-1:0] ylow_w [NS+1];
   logic [QW-1:0] yquo_w [NS+1];

   logic signed [15:0] x_out_ff, y_out_ff;

   // Magnitudes; -32768 becomes 32768 in 16 unsigned bits.
   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::STG_ABS]) begin
         side1_ff.ax <= x_in[15] ? 16'(~x_in + 16'd1) : x_in;
         side1_ff.ay <= y_in[15] ? 16'(~y_in + 16'd1) : y_in;
         side1_ff.sx <= x_in[15];
         side1_ff.sy <= y_in[15];
      end
   end

   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::STG_SQUARE]) begin
         sqx2_ff  <= 32'(side1_ff.ax) * 32'(side1_ff.ax);
         sqy2_ff  <= 32'(side1_ff.ay) * 32'(side1_ff.ay);
         side2_ff <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::STG_SUM]) begin
         sum3_ff  <= sqx2_ff + sqy2_ff;
         side3_ff <= side2_ff;
      end
   end

   assign rad_w[0]   = sum3_ff;
   assign root_w[0]  = '0;
   assign srem_w[0]  = '0;
   assign side_sq[0] = side3_ff;

   for (genvar g = 0; g < SQ; g++) begin : g_sqrt
      gdzc_sqrt_stage #(.STEPS(gdzc_pkg::SQRT_STEPS)) u_sqrt (
         .clock    (clock),
         .en       (en[gdzc_pkg::STG_SQRT0 + g]),
         .rad_in   (rad_w[g]),
         .root_in  (root_w[g]),
         .rem_in   (srem_w[g]),
         .rad_out  (rad_w[g+1]),
         .root_out (root_w[g+1]),
         .rem_out  (srem_w[g+1])
      );
      always_ff @(posedge clock) begin
         if (en[gdzc_pkg::STG_SQRT0 + g]) begin
            side_sq[g+1] <= side_sq[g];
         end
      end
   end

   // Radius: dead-zone test, clamp to full scale and the rescale terms.
   assign r_c  = root_w[SQ];
   assign rc_c = r_c[15] ? 16'h8000 : r_c;

   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::STG_RADIUS]) begin
         zero_rad_ff <= (r_c < {1'b0, dz}) || (r_c == '0);
         r_rad_ff    <= r_c;
         nd_rad_ff   <= rc_c - {1'b0, dz};
         dd_rad_ff   <= 16'h8000 - {1'b0, dz};
         side_rad_ff <= side_sq[SQ];
      end
   end

   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::STG_MUL]) begin
         nx_ff <= DW'(32'(side_rad_ff.ax) * 32'(nd_rad_ff));
         ny_ff <= DW'(32'(side_rad_ff.ay) * 32'(nd_rad_ff));
         den_ff <= DW'(32'(dd_rad_ff) * 32'(r_rad_ff));
         side_mul_ff.zero <= zero_rad_ff;
         side_mul_ff.sx   <= side_rad_ff.sx;
         side_mul_ff.sy   <= side_rad_ff.sy;
      end
   end

   // Dividend is n * 2^15; the quotient never exceeds 32768.
   assign xrem_w[0]  = {1'b0, nx_ff[DW-1:1]};
   assign xlow_w[0]  = {nx_ff[0], {(QW-1){1'b0}}};
   assign xden_w[0]  = den_ff;
   assign xquo_w[0]  = '0;
   assign yrem_w[0]  = {1'b0, ny_ff[DW-1:1]};
   assign ylow_w[0]  = {ny_ff[0], {(QW-1){1'b0}}};
   assign yden_w[0]  = den_ff;
   assign yquo_w[0]  = '0;
   assign side_div[0] = side_mul_ff;

   for (genvar g = 0; g < NS; g++) begin : g_div
      gdzc_div_stage #(.W(DW), .STEPS(gdzc_pkg::DIV_STEPS)) u_div_x (
         .clock   (clock),
         .en      (en[gdzc_pkg::STG_DIV0 + g]),
         .rem_in  (xrem_w[g]),
         .den_in  (xden_w[g]),
         .low_in  (xlow_w[g]),
         .quo_in  (xquo_w[g]),
         .rem_out (xrem_w[g+1]),
         .den_out (xden_w[g+1]),
         .low_out (xlow_w[g+1]),
         .quo_out (xquo_w[g+1])
      );
      gdzc_div_stage #(.W(DW), .STEPS(gdzc_pkg::DIV_STEPS)) u_div_y (
         .clock   (clock),
         .en      (en[gdzc_pkg::STG_DIV0 + g]),
         .rem_in  (yrem_w[g]),
         .den_in  (yden_w[g]),
         .low_in  (ylow_w[g]),
         .quo_in  (yquo_w[g]),
         .rem_out (yrem_w[g+1]),
         .den_out (yden_w[g+1]),
         .low_out (ylow_w[g+1]),
         .quo_out (yquo_w[g+1])
      );
      always_ff @(posedge clock) begin
         if (en[gdzc_pkg::STG_DIV0 + g]) begin
            side_div[g+1] <= side_div[g];
         end
      end
   end

   function automatic logic [15:0] apply_sign(input logic zero, input logic neg,
                                              input logic [15:0] q);
      logic [15:0] res;
      if (zero) begin
         res = '0;
      end else if (neg) begin
         res = 16'(~q + 16'd1);
      end else if (q[15]) begin
         res = 16'h7FFF;
      end else begin
         res = q;
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (en[gdzc_pkg::STG_OUT]) begin
         x_out_ff <= apply_sign(side_div[NS].zero, side_div[NS].sx, xquo_w[NS]);
         y_out_ff <= apply_sign(side_div[NS].zero, side_div[NS].sy, yquo_w[NS]);
      end
   end

   assign x_out = x_out_ff;
   assign y_out = y_out_ff;

endmodule

@@ hdl/gamepad_dead_zone_conditioner_top.sv @@
// Throughput: one request per cycle unless a stalled output backs up the
// pipe; the square root takes 4 root bits and each divider 2 quotient bits
// per stage, which sets the 18-stage depth. A stalled output holds every
// full stage back to the first bubble; bubbles behind it still fill.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// gamepad_dead_zone_conditioner_top
// Trigger and radial stick dead-zone conditioner with an APB register port.
// ----------------------------------------------------------------------------
module gamepad_dead_zone_conditioner_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  gdzc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output gdzc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gdzc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int PD = gdzc_pkg::PIPE_DEPTH;

   logic [PD:1] valid_ff, valid_in, en;
   logic [7:0]  thr_ff, thr_in;
   logic [14:0] ldz_ff, ldz_in, rdz_ff, rdz_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      thr_in = thr_ff;
      ldz_in = ldz_ff;
      rdz_in = rdz_ff;
      if (csr_write) begin
         unique case (csr_index)
            gdzc_pkg::CSR_TRIGGER_THRESHOLD: thr_in = csr_pwdata[7:0];
            gdzc_pkg::CSR_LEFT_DEAD_ZONE:    ldz_in = csr_pwdata[14:0];
            gdzc_pkg::CSR_RIGHT_DEAD_ZONE:   rdz_in = csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         gdzc_pkg::CSR_TRIGGER_THRESHOLD: csr_prdata = {24'd0, thr_ff};
         gdzc_pkg::CSR_LEFT_DEAD_ZONE:    csr_prdata = {17'd0, ldz_ff};
         gdzc_pkg::CSR_RIGHT_DEAD_ZONE:   csr_prdata = {17'd0, rdz_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gdzc_pkg::TRIGGER_THRESHOLD_RST;
         ldz_ff <= gdzc_pkg::LEFT_DEAD_ZONE_RST;
         rdz_ff <= gdzc_pkg::RIGHT_DEAD_ZONE_RST;
      end else begin
         thr_ff <= thr_in;
         ldz_ff <= ldz_in;
         rdz_ff <= rdz_in;
      end
   end

   // ------------------------------------------------------------ pipe control
   // A stage loads when it is empty or its contents move on this cycle.
   always_comb begin
      en[PD] = !valid_ff[PD] || rsp_ready;
      for (int s = PD - 1; s >= 1; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (en[1]) begin
         valid_in[1] = req_valid;
      end
      for (int s = 2; s <= PD; s++) begin
         if (en[s]) begin
            valid_in[s] = valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = valid_ff[PD];

   // -------------------------------------------------------------- datapaths
   gdzc_trigger u_left_trigger (
      .clock    (clock),
      .en       (en),
      .raw      (req_data.left_trigger_raw),
      .thr      (thr_ff),
      .trig_out (rsp_data.left_trigger_out)
   );

   gdzc_trigger u_right_trigger (
      .clock    (clock),
      .en       (en),
      .raw      (req_data.right_trigger_raw),
      .thr      (thr_ff),
      .trig_out (rsp_data.right_trigger_out)
   );

   gdzc_stick u_left_stick (
      .clock (clock),
      .en    (en),
      .x_in  (req_data.left_x_raw),
      .y_in  (req_data.left_y_raw),
      .dz    (ldz_ff),
      .x_out (rsp_data.left_x_out),
      .y_out (rsp_data.left_y_out)
   );

   gdzc_stick u_right_stick (
      .clock (clock),
      .en    (en),
      .x_in  (req_data.right_x_raw),
      .y_in  (req_data.right_y_raw),
      .dz    (rdz_ff),
      .x_out (rsp_data.right_x_out),
      .y_out (rsp_data.right_y_out)
   );

   // -------------------------------------------------------------- assertions
`ifndef SYNTH
   // The pipe comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> valid_ff == '0)
      else $error("pipeline not empty after reset");

   // Requests in flight change only by what enters and what leaves.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(valid_ff) == $countones($past(valid_ff))
         + int'($past(req_valid && req_ready)) - int'($past(rsp_valid && rsp_ready)))
      else $error("request lost or duplicated in pipeline");

   // A threshold write reads back the low byte of the written data.
   a_thr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == gdzc_pkg::CSR_TRIGGER_THRESHOLD
         |=> thr_ff == $past(csr_pwdata[7:0]))
      else $error("trigger threshold write not taken");
`endif

endmodule
